### rtl/pls_pkg.sv
package pls_pkg;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 12;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_INS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLR = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // remainder unit: bits of the position retired per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = POS_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // read-out tree: cells per first-level group
  localparam int GRP = 32;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_WR
  } cell_op_t;

endpackage

### rtl/positional_list_store_unit.sv
// Channel   Signals                                  Direction
// request   in_valid, in_ready, mode, position, value   in
// result    out_valid, out_ready, status, data, count  out
//
// Insert, delete, clear and unused modes: the item taken passes an execute
// state in the cell row, then a gather state; no new item is taken until the block is back in idle.
// Read and replace on a non-empty store first pass a divide state: three remainder steps
// of 4 bits each, then a registered done that hands the remainder over.
// Reset empties the store at once; cell contents are not cleared.
// A new item is taken while a result still waits; gather stalls until it leaves.
module positional_list_store_unit #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pls_pkg::MODE_W-1:0]   mode,
  input  logic [pls_pkg::POS_W-1:0]    position,
  input  logic [DATA_WIDTH-1:0]        value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pls_pkg::STATUS_W-1:0] status,
  output logic [DATA_WIDTH-1:0]        data,
  output logic [pls_pkg::COUNT_W-1:0]  count
);
  import pls_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EXEC,
    S_DONE
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [MODE_W-1:0]   mode_r;
  logic [POS_W-1:0]    pos_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [STATUS_W-1:0] res_status;
  logic                res_take;

  logic [STATUS_W-1:0] status_next;
  logic                take_next;
  logic [CNT_W-1:0]    cnt_next;
  cell_op_t            op_next;
  cell_op_t            cell_op;
  logic [IDX_W-1:0]    sel;
  logic [POS_W-1:0]    cnt_ext;

  logic                in_fire;
  logic                need_div;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;

  logic [DATA_WIDTH-1:0] word [CAPACITY];
  logic [DATA_WIDTH-1:0] tap  [CAPACITY];
  logic [DATA_WIDTH-1:0] grp_next [NGRP];
  logic [DATA_WIDTH-1:0] grp_or   [NGRP];
  logic [DATA_WIDTH-1:0] gather;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign need_div = ((mode == MODE_RD) || (mode == MODE_REP)) && (cnt != '0);
  assign cnt_ext  = {{(POS_W - CNT_W){1'b0}}, cnt};

  pls_mod_unit #(.CNT_W(CNT_W)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire && need_div),
    .dividend (position),
    .divisor  (cnt),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // command for the cell row, only acted on in the execute cycle
  always_comb begin
    status_next = ST_OK;
    take_next   = 1'b0;
    cnt_next    = cnt;
    op_next     = CELL_HOLD;
    sel         = '0;
    case (mode_r)
      MODE_INS: begin
        if (cnt == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          sel      = (pos_r < cnt_ext) ? pos_r[IDX_W-1:0] : cnt[IDX_W-1:0];
          op_next  = CELL_INS;
          cnt_next = cnt + 1'b1;
        end
      end
      MODE_DEL: begin
        if (cnt == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_r >= cnt_ext) begin
          status_next = ST_INVALID;
        end else begin
          sel       = pos_r[IDX_W-1:0];
          op_next   = CELL_DEL;
          take_next = 1'b1;
          cnt_next  = cnt - 1'b1;
        end
      end
      MODE_RD: begin
        if (cnt == '0) begin
          status_next = ST_EMPTY;
        end else begin
          sel       = mod_rem[IDX_W-1:0];
          take_next = 1'b1;
        end
      end
      MODE_REP: begin
        if (cnt == '0) begin
          status_next = ST_EMPTY;
        end else begin
          sel     = mod_rem[IDX_W-1:0];
          op_next = CELL_WR;
        end
      end
      MODE_CLR: cnt_next = '0;
      default: cnt_next = cnt;
    endcase
  end

  assign cell_op = (state == S_EXEC) ? op_next : CELL_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = word[i+1];
    end
    pls_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op),
      .sel      (sel),
      .value_in (value_r),
      .left     (left_w),
      .right    (right_w),
      .word     (word[i]),
      .tap      (tap[i])
    );
  end

  // first tree level: OR of each group of taps, registered in execute
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) grp_next[g] = grp_next[g] | tap[g * GRP + k];
      end
    end
  end

  always_comb begin
    gather = '0;
    for (int g = 0; g < NGRP; g++) gather = gather | grp_or[g];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // the gather state reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            mode_r  <= mode;
            pos_r   <= position;
            value_r <= value;
            state   <= need_div ? S_DIV : S_EXEC;
          end
        end
        S_DIV: begin
          if (mod_done) state <= S_EXEC;
        end
        S_EXEC: begin
          res_status <= status_next;
          res_take   <= take_next;
          cnt        <= cnt_next;
          for (int g = 0; g < NGRP; g++) grp_or[g] <= grp_next[g];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            data      <= res_take ? gather : '0;
            count     <= COUNT_W'(cnt);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != S_IDLE))
    else $error("block idle right after taking an item");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_DIV))
    else $error("remainder finished outside the divide state");

  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && cnt == CNT_W'(CAPACITY)) |=> (cnt != '0 || mode_r == MODE_CLR
      || mode_r == MODE_DEL || cnt == CNT_W'(CAPACITY)) && cnt <= CNT_W'(CAPACITY))
    else $error("count wrapped from full");

endmodule

### rtl/pls_cell.sv
module pls_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 6,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  pls_pkg::cell_op_t     op,
  input  logic [IDX_W-1:0]      sel,
  input  logic [DATA_WIDTH-1:0] value_in,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] tap
);
  import pls_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    case (op)
      CELL_INS: begin
        if (MY_IDX > sel) word_next = left;
        else if (MY_IDX == sel) word_next = value_in;
      end
      CELL_DEL: begin
        if (MY_IDX >= sel) word_next = right;
      end
      CELL_WR: begin
        if (MY_IDX == sel) word_next = value_in;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // old word of the selected cell, zero elsewhere, for the OR tree
  assign tap = (MY_IDX == sel) ? word : '0;

endmodule

### rtl/pls_mod_unit.sv
module pls_mod_unit #(
  parameter int CNT_W = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pls_pkg::POS_W-1:0] dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      done,
  output logic [CNT_W-1:0]          rem
);
  import pls_pkg::*;

  logic              active;
  logic [STEP_W-1:0] steps;
  logic [POS_W-1:0]  sh;
  logic [CNT_W-1:0]  rem_next;
  logic [POS_W-1:0]  sh_next;

  // restoring remainder, DIV_BITS bits per cycle
  always_comb begin
    logic [CNT_W:0]   r;
    logic [POS_W-1:0] q;
    r = {1'b0, rem};
    q = sh;
    for (int k = 0; k < DIV_BITS; k++) begin
      r = {r[CNT_W-1:0], q[POS_W-1]};
      q = {q[POS_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) r = r - {1'b0, divisor};
    end
    rem_next = r[CNT_W-1:0];
    sh_next  = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= '0;
        sh     <= dividend;
        rem    <= '0;
      end else if (active) begin
        sh    <= sh_next;
        rem   <= rem_next;
        steps <= steps + 1'b1;
        if (steps == STEP_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
